// ===== sv/rotation_matrix_to_euler_defines.svh =====
// Assertion macros shared by the block.
`ifndef ROTATION_MATRIX_TO_EULER_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RME_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RME_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rme_pkg.sv =====
package rme_pkg;

  localparam int MAT_W = 16;
  localparam int ANG_W = 16;
  localparam int THR_W = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1;

  localparam int SUM_W = 32;
  localparam int SY_W = 17;
  localparam int SQRT_ITERS = 16;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES = SQRT_ITERS / SQRT_PER_STAGE;

  localparam int OPD_W = 18;
  localparam int XY_W = 28;
  localparam int Z_W = 28;
  localparam int PRE_SHIFT = 8;
  localparam int ROUND_SHIFT = 11;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [Z_W-1:0] HALF_PI_Z = 28'sd26353589;
  localparam logic signed [Z_W-1:0] ROUND_BIAS = 28'sd1024;
  localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 16'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_ANGLE = 16'sd12868;

  typedef struct packed {
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m01;
    logic signed [MAT_W-1:0] m02;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m22;
  } matrix_t;

  function automatic int cordic_iters(input int steps);
    cordic_iters = (steps < ATAN_ENTRIES) ? steps : ATAN_ENTRIES;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
    case (idx)
      0:  atan_entry = 28'sd13176795;
      1:  atan_entry = 28'sd7778716;
      2:  atan_entry = 28'sd4110060;
      3:  atan_entry = 28'sd2086331;
      4:  atan_entry = 28'sd1047214;
      5:  atan_entry = 28'sd524117;
      6:  atan_entry = 28'sd262123;
      7:  atan_entry = 28'sd131069;
      8:  atan_entry = 28'sd65536;
      9:  atan_entry = 28'sd32768;
      10: atan_entry = 28'sd16384;
      11: atan_entry = 28'sd8192;
      12: atan_entry = 28'sd4096;
      13: atan_entry = 28'sd2048;
      14: atan_entry = 28'sd1024;
      15: atan_entry = 28'sd512;
      16: atan_entry = 28'sd256;
      17: atan_entry = 28'sd128;
      18: atan_entry = 28'sd64;
      19: atan_entry = 28'sd32;
      20: atan_entry = 28'sd16;
      21: atan_entry = 28'sd8;
      22: atan_entry = 28'sd4;
      23: atan_entry = 28'sd2;
      default: atan_entry = '0;
    endcase
  endfunction

endpackage

// ===== sv/rme_in_if.sv =====
interface rme_in_if;
  logic valid;
  logic ready;
  logic signed [rme_pkg::MAT_W-1:0] m00;
  logic signed [rme_pkg::MAT_W-1:0] m01;
  logic signed [rme_pkg::MAT_W-1:0] m02;
  logic signed [rme_pkg::MAT_W-1:0] m10;
  logic signed [rme_pkg::MAT_W-1:0] m12;
  logic signed [rme_pkg::MAT_W-1:0] m20;
  logic signed [rme_pkg::MAT_W-1:0] m22;

  modport source(output valid, m00, m01, m02, m10, m12, m20, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m12, m20, m22, output ready);
endinterface

// ===== sv/rme_out_if.sv =====
interface rme_out_if;
  logic valid;
  logic ready;
  logic signed [rme_pkg::ANG_W-1:0] roll;
  logic signed [rme_pkg::ANG_W-1:0] pitch;
  logic signed [rme_pkg::ANG_W-1:0] yaw;
  logic singular;

  modport source(output valid, roll, pitch, yaw, singular, input ready);
  modport sink(input valid, roll, pitch, yaw, singular, output ready);
endinterface

// ===== sv/rme_isqrt.sv =====
module rme_isqrt (
  input  logic                          clk,
  input  logic [rme_pkg::SQRT_STAGES-1:0] en,
  input  logic [rme_pkg::SUM_W-1:0]     n,
  output logic [rme_pkg::SY_W-1:0]      root
);

  localparam int IW = rme_pkg::SUM_W + 1;
  localparam int NS = rme_pkg::SQRT_STAGES;
  localparam int PS = rme_pkg::SQRT_PER_STAGE;

  typedef struct packed {
    logic [IW-1:0] rem;
    logic [IW-1:0] res;
  } sq_t;

  function automatic sq_t sq_step(input sq_t a, input int k);
    sq_t r;
    logic [IW-1:0] bit_v;
    logic [IW-1:0] trial;
    bit_v = IW'(1) << (2 * (rme_pkg::SQRT_ITERS - 1 - k));
    trial = a.res + bit_v;
    if (a.rem >= trial) begin
      r.rem = a.rem - trial;
      r.res = (a.res >> 1) + bit_v;
    end else begin
      r.rem = a.rem;
      r.res = a.res >> 1;
    end
    return r;
  endfunction

  sq_t st_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    sq_t cur [PS+1];

    always_comb begin
      if (s == 0) begin
        cur[0].rem = IW'(n);
        cur[0].res = '0;
      end else begin
        cur[0] = st_q[(s == 0) ? 0 : s-1];
      end
      for (int j = 0; j < PS; j++) begin
        cur[j+1] = sq_step(cur[j], s * PS + j);
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st_q[s] <= cur[PS];
      end
    end
  end

  assign root = st_q[NS-1].res[rme_pkg::SY_W-1:0];

endmodule

// ===== sv/rme_cordic.sv =====
module rme_cordic #(
  parameter int STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic [rme_pkg::cordic_iters(STEPS)+1:0] en,
  input  logic signed [rme_pkg::OPD_W-1:0]       y,
  input  logic signed [rme_pkg::OPD_W-1:0]       x,
  output logic signed [rme_pkg::ANG_W-1:0]       angle
);

  localparam int IT = rme_pkg::cordic_iters(STEPS);
  localparam int XW = rme_pkg::XY_W;
  localparam int ZW = rme_pkg::Z_W;
  localparam int AW = rme_pkg::ANG_W;
  localparam logic signed [ZW-1:0] LIM_Z = ZW'(rme_pkg::ANGLE_LIMIT);

  logic signed [XW-1:0] x_q [0:IT];
  logic signed [XW-1:0] y_q [0:IT];
  logic signed [ZW-1:0] z_q [0:IT];
  logic                 sp_q [0:IT];
  logic signed [AW-1:0] spv_q [0:IT];
  logic signed [AW-1:0] angle_q;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [AW-1:0] spv;

  assign xs = XW'(x) <<< rme_pkg::PRE_SHIFT;
  assign ys = XW'(y) <<< rme_pkg::PRE_SHIFT;

  always_comb begin
    if (y == '0) begin
      spv = (x >= 0) ? '0 : rme_pkg::ANGLE_LIMIT;
    end else begin
      spv = (y > 0) ? rme_pkg::HALF_ANGLE : -rme_pkg::HALF_ANGLE;
    end
  end

  // Vectors in the left half-plane are turned by a quarter first.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sp_q[0] <= (y == '0) || (x == '0);
      spv_q[0] <= spv;
      if (xs < 0) begin
        if (ys >= 0) begin
          x_q[0] <= ys;
          y_q[0] <= -xs;
          z_q[0] <= rme_pkg::HALF_PI_Z;
        end else begin
          x_q[0] <= -ys;
          y_q[0] <= xs;
          z_q[0] <= -rme_pkg::HALF_PI_Z;
        end
      end else begin
        x_q[0] <= xs;
        y_q[0] <= ys;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < IT; i++) begin : g_iter
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        sp_q[i+1] <= sp_q[i];
        spv_q[i+1] <= spv_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + rme_pkg::atan_entry(i);
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - rme_pkg::atan_entry(i);
        end
      end
    end
  end

  logic signed [ZW-1:0] zr;
  assign zr = (z_q[IT] + rme_pkg::ROUND_BIAS) >>> rme_pkg::ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (en[IT+1]) begin
      if (sp_q[IT]) begin
        angle_q <= spv_q[IT];
      end else if (zr > LIM_Z) begin
        angle_q <= rme_pkg::ANGLE_LIMIT;
      end else if (zr < -LIM_Z) begin
        angle_q <= -rme_pkg::ANGLE_LIMIT;
      end else begin
        angle_q <= zr[AW-1:0];
      end
    end
  end

  assign angle = angle_q;

endmodule

// ===== sv/rotation_matrix_to_euler.sv =====
// Channel   Interface      Direction  Contents
// matrix    rme_in_if      sink       m00 m01 m02 m10 m12 m20 m22, signed Q2.14
// angles    rme_out_if     source     roll pitch yaw Q3.13 radians, singular flag
// cfg       cfg_wen/wdata  write      singular_threshold, unsigned Q1.14
//
// One request is taken per cycle while matrix.ready is high; each result passes through
// squaring, sum, eight square-root stages and branch select, then
// a quarter-turn stage, one stage per CORDIC iteration and a rounding stage.
// Reset is synchronous; it empties the pipeline and sets the threshold to one LSB.
// A stalled result holds only the stages that are full; empty stages further back
// keep filling, so requests are still taken until every stage holds one.
module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [rme_pkg::THR_W-1:0] cfg_wdata,
  rme_in_if.sink                    matrix,
  rme_out_if.source                 angles
);

  `include "rotation_matrix_to_euler_defines.svh"

  localparam int IT = rme_pkg::cordic_iters(CORDIC_STEPS);
  localparam int SQ0 = 2;
  localparam int SEL = SQ0 + rme_pkg::SQRT_STAGES;
  localparam int CS0 = SEL + 1;
  localparam int DEPTH = CS0 + IT + 2;
  localparam int MW = rme_pkg::MAT_W;
  localparam int OW = rme_pkg::OPD_W;

  logic [DEPTH-1:0] v;
  logic [DEPTH-1:0] en;
  logic [rme_pkg::THR_W-1:0] thr;

  always_comb begin
    en[DEPTH-1] = !v[DEPTH-1] || angles.ready;
    for (int k = DEPTH-2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign matrix.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      thr <= rme_pkg::THR_RESET;
    end else begin
      if (cfg_wen) begin
        thr <= cfg_wdata;
      end
      if (en[0]) begin
        v[0] <= matrix.valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  rme_pkg::matrix_t mat_q [0:SEL-1];
  logic signed [2*MW-1:0] sq00;
  logic signed [2*MW-1:0] sq01;
  logic [rme_pkg::SUM_W-2:0] p00_q;
  logic [rme_pkg::SUM_W-2:0] p01_q;
  logic [rme_pkg::SUM_W-1:0] sum_q;
  logic [rme_pkg::SY_W-1:0] sy;

  assign sq00 = matrix.m00 * matrix.m00;
  assign sq01 = matrix.m01 * matrix.m01;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p00_q <= sq00[rme_pkg::SUM_W-2:0];
      p01_q <= sq01[rme_pkg::SUM_W-2:0];
      mat_q[0] <= '{m00: matrix.m00, m01: matrix.m01, m02: matrix.m02,
                    m10: matrix.m10, m12: matrix.m12, m20: matrix.m20,
                    m22: matrix.m22};
    end
    if (en[1]) begin
      sum_q <= rme_pkg::SUM_W'(p00_q) + rme_pkg::SUM_W'(p01_q);
    end
    for (int k = 1; k < SEL; k++) begin
      if (en[k]) begin
        mat_q[k] <= mat_q[k-1];
      end
    end
  end

  rme_isqrt u_isqrt (
    .clk  (clk),
    .en   (en[SQ0 +: rme_pkg::SQRT_STAGES]),
    .n    (sum_q),
    .root (sy)
  );

  logic sing;
  logic sg_q [SEL:DEPTH-1];
  logic signed [OW-1:0] pit_y_q, pit_x_q, rol_y_q, rol_x_q, yaw_y_q, yaw_x_q;
  rme_pkg::matrix_t ms;

  assign ms = mat_q[SEL-1];
  assign sing = sy < rme_pkg::SY_W'(thr);

  // When singular, yaw is fed a zero vector, whose angle is zero.
  always_ff @(posedge clk) begin
    if (en[SEL]) begin
      sg_q[SEL] <= sing;
      pit_y_q <= -OW'(ms.m02);
      pit_x_q <= OW'({1'b0, sy});
      if (sing) begin
        rol_y_q <= OW'(ms.m10);
        rol_x_q <= OW'(ms.m20);
        yaw_y_q <= '0;
        yaw_x_q <= '0;
      end else begin
        rol_y_q <= OW'(ms.m12);
        rol_x_q <= OW'(ms.m22);
        yaw_y_q <= OW'(ms.m01);
        yaw_x_q <= OW'(ms.m00);
      end
    end
    for (int k = SEL+1; k < DEPTH; k++) begin
      if (en[k]) begin
        sg_q[k] <= sg_q[k-1];
      end
    end
  end

  logic signed [rme_pkg::ANG_W-1:0] roll_a, pitch_a, yaw_a;

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk   (clk),
    .en    (en[CS0 +: IT+2]),
    .y     (rol_y_q),
    .x     (rol_x_q),
    .angle (roll_a)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk   (clk),
    .en    (en[CS0 +: IT+2]),
    .y     (pit_y_q),
    .x     (pit_x_q),
    .angle (pitch_a)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk   (clk),
    .en    (en[CS0 +: IT+2]),
    .y     (yaw_y_q),
    .x     (yaw_x_q),
    .angle (yaw_a)
  );

  assign angles.valid = v[DEPTH-1];
  assign angles.roll = roll_a;
  assign angles.pitch = pitch_a;
  assign angles.yaw = yaw_a;
  assign angles.singular = sg_q[DEPTH-1];

  `RME_ASSERT_IMP(a_yaw_zero, clk, rst, angles.valid && angles.singular, angles.yaw == '0, "yaw not zero in the singular case")
  `RME_ASSERT_IMP(a_roll_range, clk, rst, angles.valid, (angles.roll <= rme_pkg::ANGLE_LIMIT) && (angles.roll >= -rme_pkg::ANGLE_LIMIT), "roll out of range")
  `RME_ASSERT_IMP(a_ready_full, clk, rst, !matrix.ready, v[0], "input held off while the first stage is empty")
  `RME_ASSERT_NXT(a_take_fill, clk, rst, matrix.valid && matrix.ready, v[0], "accepted request did not enter the pipeline")

endmodule
